// File: src/swl_pkg.sv
// ----------------------------------------------------------------------------
// swl_pkg: stopwatch shared definitions
// Mode codes, the view struct and the seven-segment digit encoder.
// ----------------------------------------------------------------------------
package swl_pkg;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;

   localparam logic [3:0] KEY_START = 4'b0001;
   localparam logic [3:0] KEY_PAUSE = 4'b0010;
   localparam logic [3:0] KEY_LAP   = 4'b0100;
   localparam logic [3:0] KEY_CLEAR = 4'b1000;

   localparam logic [6:0] HUND_LAST = 7'd99;
   localparam logic [5:0] SEC_LAST  = 6'd59;
   localparam logic [5:0] MIN_LAST  = 6'd59;

   localparam logic [15:0] LAP_DOT = 16'h8000;

   // what the display stage needs for one beat
   typedef struct packed {
      logic [6:0] hund;
      logic [5:0] secs;
      logic [5:0] mins;
      logic       lap_view;
      logic       running;
   } view_type;

   function automatic logic [7:0] seg7(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'h0: s = 8'h3F;
         4'h1: s = 8'h06;
         4'h2: s = 8'h5B;
         4'h3: s = 8'h4F;
         4'h4: s = 8'h66;
         4'h5: s = 8'h6D;
         4'h6: s = 8'h7D;
         4'h7: s = 8'h07;
         4'h8: s = 8'h7F;
         4'h9: s = 8'h6F;
         4'hA: s = 8'h77;
         4'hB: s = 8'h7C;
         4'hC: s = 8'h39;
         4'hD: s = 8'h5E;
         4'hE: s = 8'h79;
         4'hF: s = 8'h71;
         default: s = 8'h3F;
      endcase
      return s;
   endfunction

   // tens by reciprocal multiply (exact for all 7-bit values), ones by subtract
   function automatic logic [15:0] two_digits(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {8'd0, v} * 15'd205;
      tens = prod[14:11];
      ones = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
      return {seg7(tens), seg7(ones[3:0])};
   endfunction

endpackage

// File: src/swl_if.sv
// ----------------------------------------------------------------------------
// swl_req_if / swl_rsp_if: stopwatch channels
// Valid/ready channels carrying key samples in and segment patterns out.
// ----------------------------------------------------------------------------
interface swl_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] keys;
   logic       tick;
   logic       show_split;

   modport source (output valid, output keys, output tick, output show_split,
                   input ready);
   modport sink   (input valid, input keys, input tick, input show_split,
                   output ready);
endinterface

interface swl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] low_digits;
   logic [15:0] high_digits;
   logic        running;

   modport source (output valid, output low_digits, output high_digits,
                   output running, input ready);
   modport sink   (input valid, input low_digits, input high_digits,
                   input running, output ready);
endinterface

// File: src/swl_core.sv
// ----------------------------------------------------------------------------
// swl_core: stopwatch mode and time keeping
// Key edge detect, run/pause/idle control, time and lap registers.
// ----------------------------------------------------------------------------
module swl_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [3:0]        keys,
   input  logic              tick,
   input  logic              show_split,
   output swl_pkg::view_type view
);

   logic [6:0] hund_ff, hund_in, lap_hund_ff, lap_hund_in;
   logic [5:0] secs_ff, secs_in, lap_secs_ff, lap_secs_in;
   logic [5:0] mins_ff, mins_in, lap_mins_ff, lap_mins_in;
   logic [3:0] last_keys_ff;
   logic [1:0] mode_ff, mode_in;
   logic [3:0] pressed;
   logic       lap_view;

   // any change of the key levels counts the whole new pattern as pressed
   assign pressed = (keys != last_keys_ff) ? keys : 4'd0;

   always_comb begin
      hund_in     = hund_ff;
      secs_in     = secs_ff;
      mins_in     = mins_ff;
      lap_hund_in = lap_hund_ff;
      lap_secs_in = lap_secs_ff;
      lap_mins_in = lap_mins_ff;
      mode_in     = mode_ff;
      case (mode_ff)
         swl_pkg::MODE_RUN: begin
            if ((pressed & swl_pkg::KEY_PAUSE) != 4'd0) begin
               mode_in = swl_pkg::MODE_PAUSE;
            end else if ((pressed & swl_pkg::KEY_LAP) != 4'd0) begin
               lap_hund_in = hund_ff;
               lap_secs_in = secs_ff;
               lap_mins_in = mins_ff;
            end else if ((pressed & swl_pkg::KEY_CLEAR) != 4'd0) begin
               hund_in     = 7'd0;
               secs_in     = 6'd0;
               mins_in     = 6'd0;
               lap_hund_in = 7'd0;
               lap_secs_in = 6'd0;
               lap_mins_in = 6'd0;
               mode_in     = swl_pkg::MODE_IDLE;
            end else if (tick) begin
               if (hund_ff >= swl_pkg::HUND_LAST) begin
                  hund_in = 7'd0;
                  if (secs_ff >= swl_pkg::SEC_LAST) begin
                     secs_in = 6'd0;
                     mins_in = (mins_ff >= swl_pkg::MIN_LAST) ? 6'd0 : mins_ff + 6'd1;
                  end else begin
                     secs_in = secs_ff + 6'd1;
                  end
               end else begin
                  hund_in = hund_ff + 7'd1;
               end
            end
         end
         swl_pkg::MODE_PAUSE: begin
            if ((pressed & swl_pkg::KEY_START) != 4'd0) begin
               mode_in = swl_pkg::MODE_RUN;
            end
         end
         default: begin
            // idle, and the unused code behaves the same
            if ((pressed & swl_pkg::KEY_START) != 4'd0) begin
               hund_in = 7'd0;
               secs_in = 6'd0;
               mins_in = 6'd0;
               mode_in = swl_pkg::MODE_RUN;
            end else begin
               mode_in = swl_pkg::MODE_IDLE;
            end
         end
      endcase
   end

   assign lap_view      = (mode_in == swl_pkg::MODE_RUN) && show_split;
   assign view.hund     = lap_view ? lap_hund_in : hund_in;
   assign view.secs     = lap_view ? lap_secs_in : secs_in;
   assign view.mins     = lap_view ? lap_mins_in : mins_in;
   assign view.lap_view = lap_view;
   assign view.running  = (mode_in == swl_pkg::MODE_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         hund_ff      <= 7'd0;
         secs_ff      <= 6'd0;
         mins_ff      <= 6'd0;
         lap_hund_ff  <= 7'd0;
         lap_secs_ff  <= 6'd0;
         lap_mins_ff  <= 6'd0;
         last_keys_ff <= 4'd0;
         mode_ff      <= swl_pkg::MODE_IDLE;
      end else if (accept) begin
         hund_ff      <= hund_in;
         secs_ff      <= secs_in;
         mins_ff      <= mins_in;
         lap_hund_ff  <= lap_hund_in;
         lap_secs_ff  <= lap_secs_in;
         lap_mins_ff  <= lap_mins_in;
         last_keys_ff <= keys;
         mode_ff      <= mode_in;
      end
   end

endmodule

// File: src/swl_disp.sv
// ----------------------------------------------------------------------------
// swl_disp: segment encode and result register
// Turns the chosen time into segment bytes and holds them for the receiver.
// ----------------------------------------------------------------------------
module swl_disp (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  swl_pkg::view_type view,
   input  logic              rsp_ready,
   output logic              req_ready,
   output logic              rsp_valid,
   output logic [31:0]       low_digits,
   output logic [15:0]       high_digits,
   output logic              running
);

   logic        valid_ff;
   logic [31:0] low_ff, low_in;
   logic [15:0] high_ff, high_in;
   logic        run_ff;

   assign low_in  = {swl_pkg::two_digits(view.secs[5:0] == 6'd0 ? 7'd0 : {1'b0, view.secs}),
                     swl_pkg::two_digits(view.hund)};
   assign high_in = swl_pkg::two_digits({1'b0, view.mins})
                    | (view.lap_view ? swl_pkg::LAP_DOT : 16'd0);

   // register frees up in the same cycle the held beat is taken
   assign req_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         low_ff  <= low_in;
         high_ff <= high_in;
         run_ff  <= view.running;
      end
   end

   assign rsp_valid   = valid_ff;
   assign low_digits  = low_ff;
   assign high_digits = high_ff;
   assign running     = run_ff;

endmodule

// File: src/stopwatch_lap_seven_segment.sv
// ----------------------------------------------------------------------------
// stopwatch_lap_seven_segment: MM:SS.hh stopwatch with lap and segment output
// Top level joining the time-keeping core and the segment result stage.
// ----------------------------------------------------------------------------
// Use:
//  - req_bus (sink) takes one beat per clock sample: raw keys, hundredth tick
//    and the split-view switch. A beat is taken when valid and ready are high.
//  - rsp_bus (source) returns exactly one beat per request beat: four segment
//    bytes for seconds and hundredths, two for minutes (bit 15 marks the lap
//    view) and the running flag.
//  - Response follows in the cycle after acceptance. Throughput is one beat
//    per cycle unless the receiver stalls; the state update and the segment
//    encode sit between the accepted request and the single result register.
//  - If the receiver stalls, the result register holds its beat and
//    req_bus.ready stays high only when that beat leaves in the same cycle,
//    so no beat is dropped and the state never runs ahead of the output.
//  - Synchronous reset clears time, lap and key history, enters idle and
//    empties the result register.
// ----------------------------------------------------------------------------
module stopwatch_lap_seven_segment (
   input logic          clock,
   input logic          reset,
   swl_req_if.sink      req_bus,
   swl_rsp_if.source    rsp_bus
);

   swl_pkg::view_type view;
   logic              accept;
   logic              ready;

   // a beat is taken only when the result register can receive its answer
   assign accept        = req_bus.valid && ready;
   assign req_bus.ready = ready;

   swl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .keys       (req_bus.keys),
      .tick       (req_bus.tick),
      .show_split (req_bus.show_split),
      .view       (view)
   );

   swl_disp u_disp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .view        (view),
      .rsp_ready   (rsp_bus.ready),
      .req_ready   (ready),
      .rsp_valid   (rsp_bus.valid),
      .low_digits  (rsp_bus.low_digits),
      .high_digits (rsp_bus.high_digits),
      .running     (rsp_bus.running)
   );

endmodule
